// ===== rtl/core/arp_cache_with_request_retry_core_assert.svh =====
// Assertion macros used by the checker file of the ARP cache core.
`ifndef ARP_CACHE_WITH_REQUEST_RETRY_CORE_ASSERT_SVH
`define ARP_CACHE_WITH_REQUEST_RETRY_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ARPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ARPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/arpc_pkg.sv =====
// Package of the ARP cache core: sizes, codes, entry layouts and states.
package arpc_pkg;

    localparam int CACHE_ENTRIES = 32;
    localparam int PENDING_SLOTS = 16;

    localparam int CIDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int PIDX_W = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int TIME_W  = 32;
    localparam int TRIES_W = 4;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_QUEUE  = 2'd2,
        CMD_TICK   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_LOOKUP      = 3'd0,
        KIND_INSERT      = 3'd1,
        KIND_QUEUE       = 3'd2,
        KIND_SEND        = 3'd3,
        KIND_UNREACHABLE = 3'd4,
        KIND_TICK_DONE   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        CFG_CACHE_TIMEOUT   = 2'd0,
        CFG_RETRY_LIMIT     = 2'd1,
        CFG_RESEND_INTERVAL = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CSWEEP,
        S_LK_DONE,
        S_P_RD,
        S_P_CHK,
        S_IN_WR,
        S_Q_DONE,
        S_TK_DONE
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0] added;
        logic [MAC_W-1:0]  mac;
        logic [IP_W-1:0]   ip;
    } t_centry;

    typedef struct packed {
        logic [TRIES_W-1:0] tries;
        logic [TIME_W-1:0]  sent;
        logic [IP_W-1:0]    ip;
    } t_pentry;

endpackage

// ===== rtl/core/arpc_ram.sv =====
// Generic single-port RAM with registered read (read-before-write).
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/arp_cache_with_request_retry_core.sv =====
// ARP cache core: IP-to-MAC cache with a pending request table and retry sweep.
//
//  channel  | dir | handshake            | contents
//  ---------+-----+----------------------+------------------------------------------
//  s stream | in  | i_s_tvalid/o_s_tready| tuser cmd; tdata ip_addr, mac_addr
//  m stream | out | o_m_tvalid/i_m_tready| tuser kind; tdata out_ip, out_mac, hit,
//           |     |                      | table_full; tlast last
//  cfg      | in  | i_cfg_we             | i_cfg_addr index, i_cfg_data value
//
// Lookup, insert, queue and tick times are all set by the single port of
//   each entry RAM, which the sweeps walk one entry at a time.
// Cache sweep is pipelined (one entry/cycle); pending walk is read then check.
// Reset clears valid bits and clock and loads config defaults; RAM contents need no clearing.
// Output stalls hold the sequencer at its emitting state; input taken only
// while idle; one beat per item, plus one per due request in a tick.
module arp_cache_with_request_retry_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [79:0]  i_s_tdata,   // [31:0] ip_addr, [79:32] mac_addr
    input  logic [1:0]   i_s_tuser,   // [1:0] cmd
    // master stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [87:0]  o_m_tdata,   // [31:0] out_ip, [79:32] out_mac, [80] hit,
                                      // [81] table_full, [87:82] zero
    output logic [2:0]   o_m_tuser,   // [2:0] kind
    output logic         o_m_tlast,
    // config write port
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_data
);
    localparam int CN = arpc_pkg::CACHE_ENTRIES;
    localparam int PN = arpc_pkg::PENDING_SLOTS;
    localparam int CW = arpc_pkg::CIDX_W;
    localparam int PW = arpc_pkg::PIDX_W;

    // ---------------- registers ----------------
    arpc_pkg::t_state r_state, n_state;

    logic [15:0] r_cfg_timeout;
    logic [3:0]  r_cfg_limit;
    logic [7:0]  r_cfg_interval;

    logic [arpc_pkg::TIME_W-1:0] r_now, n_now;
    logic [CN-1:0] r_cvalid, n_cvalid;
    logic [PN-1:0] r_pvalid, n_pvalid;

    arpc_pkg::t_cmd              r_cmd, n_cmd;
    logic [arpc_pkg::IP_W-1:0]   r_ip, n_ip;
    logic [arpc_pkg::MAC_W-1:0]  r_mac, n_mac;

    logic [CW:0]   r_cidx, n_cidx;       // issue pointer of cache sweep
    logic          r_chk, n_chk;         // read data of r_chk_idx present
    logic [CW-1:0] r_chk_idx, n_chk_idx;
    logic [PW-1:0] r_pidx, n_pidx;
    logic          r_hit, n_hit;         // lookup match / pending found
    logic [arpc_pkg::MAC_W-1:0] r_fmac, n_fmac;

    // output register
    logic                       r_ov, n_ov;
    arpc_pkg::t_kind            r_okind, n_okind;
    logic [arpc_pkg::IP_W-1:0]  r_oip, n_oip;
    logic [arpc_pkg::MAC_W-1:0] r_omac, n_omac;
    logic r_ohit, n_ohit, r_ofull, n_ofull, r_olast, n_olast;

    // ---------------- memories ----------------
    logic              c_we, p_we;
    logic [CW-1:0]     c_addr;
    logic [PW-1:0]     p_addr;
    arpc_pkg::t_centry c_wdata, c_rdata;
    arpc_pkg::t_pentry p_wdata, p_rdata;

    arpc_ram #(.WIDTH($bits(arpc_pkg::t_centry)), .DEPTH(CN)) u_cache_ram (
        .i_clk(i_clk), .i_we(c_we), .i_addr(c_addr), .i_wdata(c_wdata), .o_rdata(c_rdata)
    );
    arpc_ram #(.WIDTH($bits(arpc_pkg::t_pentry)), .DEPTH(PN)) u_pend_ram (
        .i_clk(i_clk), .i_we(p_we), .i_addr(p_addr), .i_wdata(p_wdata), .o_rdata(p_rdata)
    );

    // ---------------- shared conditions ----------------
    logic s_acc, can_put, c_done, p_last;
    logic pv, pmatch, pdue, punreach, p_adv;
    logic [CW-1:0] cfree_idx;
    logic          cfree_ok;
    logic [PW-1:0] pfree_idx;
    logic          pfree_ok;
    logic [arpc_pkg::TIME_W-1:0] c_age, p_age;

    assign s_acc   = i_s_tvalid && o_s_tready;
    assign can_put = !r_ov || i_m_tready;
    assign c_done  = (r_cidx == (CW+1)'(CN)) && !r_chk;
    assign p_last  = (r_pidx == PW'(PN - 1));

    assign pv       = r_pvalid[r_pidx];
    assign pmatch   = pv && (p_rdata.ip == r_ip);
    assign p_age    = r_now - p_rdata.sent;
    assign pdue     = pv && ((p_rdata.tries == '0) || (p_age > {24'd0, r_cfg_interval}));
    assign punreach = p_rdata.tries >= r_cfg_limit;
    // a due request in the tick walk waits for room in the output register
    assign p_adv    = !((r_cmd == arpc_pkg::CMD_TICK) && pdue && !can_put);
    assign c_age    = r_now - c_rdata.added;

    // lowest free slots
    always_comb begin
        cfree_idx = '0;
        cfree_ok  = 1'b0;
        for (int i = CN - 1; i >= 0; i--) begin
            if (!r_cvalid[i]) begin
                cfree_idx = CW'(i);
                cfree_ok  = 1'b1;
            end
        end
    end

    always_comb begin
        pfree_idx = '0;
        pfree_ok  = 1'b0;
        for (int i = PN - 1; i >= 0; i--) begin
            if (!r_pvalid[i]) begin
                pfree_idx = PW'(i);
                pfree_ok  = 1'b1;
            end
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            arpc_pkg::S_IDLE: begin
                if (s_acc) begin
                    if (i_s_tuser == arpc_pkg::CMD_LOOKUP || i_s_tuser == arpc_pkg::CMD_TICK) begin
                        n_state = arpc_pkg::S_CSWEEP;
                    end else begin
                        n_state = arpc_pkg::S_P_RD;
                    end
                end
            end
            arpc_pkg::S_CSWEEP: begin
                if (c_done) begin
                    n_state = (r_cmd == arpc_pkg::CMD_TICK) ? arpc_pkg::S_P_RD
                                                            : arpc_pkg::S_LK_DONE;
                end
            end
            arpc_pkg::S_LK_DONE: begin
                if (can_put) n_state = arpc_pkg::S_IDLE;
            end
            arpc_pkg::S_P_RD: n_state = arpc_pkg::S_P_CHK;
            arpc_pkg::S_P_CHK: begin
                if (r_cmd == arpc_pkg::CMD_INSERT) begin
                    if (pmatch || p_last) n_state = arpc_pkg::S_IN_WR;
                    else                  n_state = arpc_pkg::S_P_RD;
                end else if (r_cmd == arpc_pkg::CMD_QUEUE) begin
                    if (pmatch || p_last) n_state = arpc_pkg::S_Q_DONE;
                    else                  n_state = arpc_pkg::S_P_RD;
                end else if (p_adv) begin
                    n_state = p_last ? arpc_pkg::S_TK_DONE : arpc_pkg::S_P_RD;
                end
            end
            arpc_pkg::S_IN_WR, arpc_pkg::S_Q_DONE, arpc_pkg::S_TK_DONE: begin
                if (can_put) n_state = arpc_pkg::S_IDLE;
            end
            default: n_state = arpc_pkg::S_IDLE;
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb begin
        n_now     = r_now;
        n_cvalid  = r_cvalid;
        n_pvalid  = r_pvalid;
        n_cmd     = r_cmd;
        n_ip      = r_ip;
        n_mac     = r_mac;
        n_cidx    = r_cidx;
        n_chk     = 1'b0;
        n_chk_idx = r_cidx[CW-1:0];
        n_pidx    = r_pidx;
        n_hit     = r_hit;
        n_fmac    = r_fmac;

        n_ov    = r_ov && !i_m_tready;
        n_okind = r_okind;
        n_oip   = r_oip;
        n_omac  = r_omac;
        n_ohit  = r_ohit;
        n_ofull = r_ofull;
        n_olast = r_olast;

        c_we    = 1'b0;
        c_addr  = r_cidx[CW-1:0];
        c_wdata = '{added: r_now, mac: r_mac, ip: r_ip};
        p_we    = 1'b0;
        p_addr  = r_pidx;
        p_wdata = '{tries: p_rdata.tries + 1'b1, sent: r_now, ip: p_rdata.ip};

        case (r_state)
            arpc_pkg::S_IDLE: begin
                if (s_acc) begin
                    n_cmd  = arpc_pkg::t_cmd'(i_s_tuser);
                    n_ip   = i_s_tdata[31:0];
                    n_mac  = i_s_tdata[79:32];
                    n_cidx = '0;
                    n_pidx = '0;
                    n_hit  = 1'b0;
                    n_fmac = '0;
                    if (i_s_tuser == arpc_pkg::CMD_TICK) n_now = r_now + 1'b1;
                end
            end
            arpc_pkg::S_CSWEEP: begin
                if (r_cidx != (CW+1)'(CN)) begin
                    n_cidx = r_cidx + 1'b1;
                    n_chk  = 1'b1;
                end
                if (r_chk && r_cvalid[r_chk_idx]) begin
                    if (r_cmd == arpc_pkg::CMD_TICK) begin
                        if (c_age > {16'd0, r_cfg_timeout}) n_cvalid[r_chk_idx] = 1'b0;
                    end else if (c_rdata.ip == r_ip) begin
                        // later (higher) matches override earlier ones
                        n_hit  = 1'b1;
                        n_fmac = c_rdata.mac;
                    end
                end
            end
            arpc_pkg::S_LK_DONE: begin
                if (can_put) begin
                    n_ov = 1'b1; n_okind = arpc_pkg::KIND_LOOKUP; n_oip = r_ip;
                    n_omac = r_fmac; n_ohit = r_hit; n_ofull = 1'b0; n_olast = 1'b1;
                end
            end
            arpc_pkg::S_P_CHK: begin
                if (r_cmd == arpc_pkg::CMD_INSERT || r_cmd == arpc_pkg::CMD_QUEUE) begin
                    if (pmatch) begin
                        n_hit = 1'b1;
                        if (r_cmd == arpc_pkg::CMD_INSERT) n_pvalid[r_pidx] = 1'b0;
                    end else if (!p_last) begin
                        n_pidx = r_pidx + 1'b1;
                    end
                end else begin
                    if (pdue && can_put) begin
                        n_ov = 1'b1; n_oip = p_rdata.ip; n_omac = '0;
                        n_ohit = 1'b0; n_ofull = 1'b0; n_olast = 1'b0;
                        if (punreach) begin
                            n_okind = arpc_pkg::KIND_UNREACHABLE;
                            n_pvalid[r_pidx] = 1'b0;
                        end else begin
                            n_okind = arpc_pkg::KIND_SEND;
                            p_we    = 1'b1;
                        end
                    end
                    if (p_adv && !p_last) n_pidx = r_pidx + 1'b1;
                end
            end
            arpc_pkg::S_IN_WR: begin
                c_addr = cfree_idx;
                if (can_put) begin
                    if (cfree_ok) begin
                        c_we = 1'b1;
                        n_cvalid[cfree_idx] = 1'b1;
                    end
                    n_ov = 1'b1; n_okind = arpc_pkg::KIND_INSERT; n_oip = r_ip;
                    n_omac = '0; n_ohit = r_hit; n_ofull = 1'b0; n_olast = 1'b1;
                end
            end
            arpc_pkg::S_Q_DONE: begin
                p_addr  = pfree_idx;
                p_wdata = '{tries: '0, sent: '0, ip: r_ip};
                if (can_put) begin
                    n_ov = 1'b1; n_okind = arpc_pkg::KIND_QUEUE; n_oip = r_ip;
                    n_omac = '0; n_olast = 1'b1;
                    n_ohit  = !r_hit && pfree_ok;
                    n_ofull = !r_hit && !pfree_ok;
                    if (!r_hit && pfree_ok) begin
                        p_we = 1'b1;
                        n_pvalid[pfree_idx] = 1'b1;
                    end
                end
            end
            arpc_pkg::S_TK_DONE: begin
                if (can_put) begin
                    n_ov = 1'b1; n_okind = arpc_pkg::KIND_TICK_DONE; n_oip = '0;
                    n_omac = '0; n_ohit = 1'b0; n_ofull = 1'b0; n_olast = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= arpc_pkg::S_IDLE;
            r_cfg_timeout  <= 16'd15;
            r_cfg_limit    <= 4'd5;
            r_cfg_interval <= 8'd1;
            r_now          <= '0;
            r_cvalid       <= '0;
            r_pvalid       <= '0;
            r_chk          <= 1'b0;
            r_ov           <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_now    <= n_now;
            r_cvalid <= n_cvalid;
            r_pvalid <= n_pvalid;
            r_chk    <= n_chk;
            r_ov     <= n_ov;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    arpc_pkg::CFG_CACHE_TIMEOUT:   r_cfg_timeout  <= i_cfg_data;
                    arpc_pkg::CFG_RETRY_LIMIT:     r_cfg_limit    <= i_cfg_data[3:0];
                    arpc_pkg::CFG_RESEND_INTERVAL: r_cfg_interval <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_ip      <= n_ip;
        r_mac     <= n_mac;
        r_cidx    <= n_cidx;
        r_chk_idx <= n_chk_idx;
        r_pidx    <= n_pidx;
        r_hit     <= n_hit;
        r_fmac    <= n_fmac;
        r_okind   <= n_okind;
        r_oip     <= n_oip;
        r_omac    <= n_omac;
        r_ohit    <= n_ohit;
        r_ofull   <= n_ofull;
        r_olast   <= n_olast;
    end

    assign o_s_tready = (r_state == arpc_pkg::S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {6'd0, r_ofull, r_ohit, r_omac, r_oip};
endmodule

// ===== rtl/core/arpc_checker.sv =====
// Port-level checker of the ARP cache core and its bind.
`include "arp_cache_with_request_retry_core_assert.svh"

module arpc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [87:0]  o_m_tdata,
    input logic [2:0]   o_m_tuser,
    input logic         o_m_tlast
);
    logic s_beat, m_beat, single_kind, sweep_kind;

    assign s_beat      = i_s_tvalid && o_s_tready;
    assign m_beat      = o_m_tvalid && i_m_tready;
    assign single_kind = (o_m_tuser == arpc_pkg::KIND_LOOKUP) ||
                         (o_m_tuser == arpc_pkg::KIND_INSERT) ||
                         (o_m_tuser == arpc_pkg::KIND_QUEUE)  ||
                         (o_m_tuser == arpc_pkg::KIND_TICK_DONE);
    assign sweep_kind  = (o_m_tuser == arpc_pkg::KIND_SEND) ||
                         (o_m_tuser == arpc_pkg::KIND_UNREACHABLE);

    `ARPC_ASSERT_NEXT(a_m_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid, "m beat dropped while stalled")
    `ARPC_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, s_beat, !o_s_tready, "s beat taken while item in flight")
    `ARPC_ASSERT_NOW(a_last_single, i_clk, i_rst_n, m_beat && single_kind, o_m_tlast, "closing result without tlast")
    `ARPC_ASSERT_NOW(a_sweep_not_last, i_clk, i_rst_n, m_beat && sweep_kind, !o_m_tlast && (o_m_tdata[81:32] == '0), "bad send or unreachable beat")
endmodule

bind arp_cache_with_request_retry_core arpc_checker u_arpc_checker (.*);
